>>> hdl/mtpc_pkg.sv
// shared types, codes and helper functions for the memory test pattern checker
package mtpc_pkg;

  // field widths
  localparam int DATA_W      = 32;
  localparam int WINDEX_W    = 24;
  localparam int OFFSET_W    = 26;
  localparam int COUNT_W     = 25;
  localparam int OUT_TDATA_W = 88;
  localparam int INDEX_BITS_DEF = 24;

  // item kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_CHECK   = 2'd2
  } action_t;

  // pattern modes
  localparam logic [2:0] MODE_WALK_ONE   = 3'd0;
  localparam logic [2:0] MODE_WALK_ZERO  = 3'd1;
  localparam logic [2:0] MODE_OWN_ADDR   = 3'd2;
  localparam logic [2:0] MODE_INVERSION  = 3'd3;
  localparam logic [2:0] MODE_RAND_INV   = 3'd4;

  // word width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;

  // configuration register indexes
  localparam logic [1:0] REG_TEST_MODE   = 2'd0;
  localparam logic [1:0] REG_WORD_WIDTH  = 2'd1;
  localparam logic [1:0] REG_RANDOM_SEED = 2'd2;
  localparam logic [1:0] REG_WORD_COUNT  = 2'd3;

  // configuration reset values
  localparam logic [2:0]         RESET_TEST_MODE  = MODE_WALK_ONE;
  localparam logic [1:0]         RESET_WORD_WIDTH = 2'd2;
  localparam logic [DATA_W-1:0]  RESET_SEED       = 32'd1;
  localparam logic [COUNT_W-1:0] RESET_WORD_COUNT = 25'h100_0000;

  localparam logic [DATA_W-1:0] LFSR_TOGGLE = 32'hD000_0001;

  typedef struct packed {
    logic restart;
    logic advance;
  } gen_ctrl_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] code);
    logic [DATA_W-1:0] m;
    case (code)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // log2 of bytes per word
  function automatic logic [1:0] width_shift(input logic [1:0] code);
    logic [1:0] s;
    case (code)
      WIDTH_8:  s = 2'd0;
      WIDTH_16: s = 2'd1;
      default:  s = 2'd2;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/memory_test_pattern_checker_core.sv
// memory test pattern checker: top level with input register, counter and result register
//
// Items arrive on the s_axis channel: tuser selects restart, fill or check and
// tdata carries the word read back from memory (used by check only). Every item
// gives exactly one result on m_axis: the pattern, its word index and byte
// offset, a mismatch flag for check items, and tlast on the final word of the
// region. Restart items and unknown kinds give a result of all zeros.
// An item is taken into an input register, the generator and counter work on
// it from there and the result lands in an output register. One item is taken
// every cycle while the receiver keeps up with the results.
// A result waiting on a stalled receiver does not block input: the input
// register still takes one more item, and only then s_axis_tready falls.
// Configuration is written through cfg_wen/cfg_index/cfg_data; the user must
// write it only while no item is in flight, the block does not enforce this.
// Reset loads the default configuration (walking one, 32-bit words, seed 1,
// 2^24 words) and restarts the generator; no valid results remain after reset.
module memory_test_pattern_checker_core #(
  parameter int INDEX_BITS = mtpc_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_wen,
  input  logic [1:0]                       cfg_index,
  input  logic [mtpc_pkg::DATA_W-1:0]      cfg_data,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mtpc_pkg::DATA_W-1:0]      s_axis_tdata,   // read_data
  input  logic [1:0]                       s_axis_tuser,   // action
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pattern, word_index, byte_offset, mismatch, zero fill
  output logic [mtpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);
  import mtpc_pkg::*;

  localparam int WideW = 34;
  localparam int CmpW  = (INDEX_BITS + 1 > COUNT_W) ? INDEX_BITS + 1 : COUNT_W;
  localparam int PadW  = OUT_TDATA_W - DATA_W - WINDEX_W - OFFSET_W - 1;

  // configuration registers
  logic [2:0]         test_mode;
  logic [1:0]         word_width;
  logic [DATA_W-1:0]  random_seed;
  logic [COUNT_W-1:0] word_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_mode   <= RESET_TEST_MODE;
      word_width  <= RESET_WORD_WIDTH;
      random_seed <= RESET_SEED;
      word_count  <= RESET_WORD_COUNT;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TEST_MODE:   test_mode   <= cfg_data[2:0];
        REG_WORD_WIDTH:  word_width  <= cfg_data[1:0];
        REG_RANDOM_SEED: random_seed <= cfg_data;
        REG_WORD_COUNT:  word_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_valid;
  logic [1:0]        in_action;
  logic [DATA_W-1:0] in_data;
  logic              advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action <= s_axis_tuser;
      in_data   <= s_axis_tdata;
    end
  end

  // generator control
  logic              is_restart;
  logic              is_step;
  logic              is_check;
  gen_ctrl_t         gen_ctrl;
  logic [DATA_W-1:0] word_mask;
  logic [DATA_W-1:0] gen_pattern;

  assign is_restart       = (in_action == ACT_RESTART);
  assign is_check         = (in_action == ACT_CHECK);
  assign is_step          = (in_action == ACT_FILL) || is_check;
  assign gen_ctrl.restart = advance && is_restart;
  assign gen_ctrl.advance = advance && is_step;
  assign word_mask        = width_mask(word_width);

  mtpc_gen u_gen (
    .clk         (clk),
    .rst         (rst),
    .test_mode   (test_mode),
    .word_mask   (word_mask),
    .random_seed (random_seed),
    .ctrl        (gen_ctrl),
    .pattern     (gen_pattern)
  );

  // word counter
  logic [INDEX_BITS-1:0] word_counter;
  logic [WideW-1:0]      idx_wide;
  logic [WideW-1:0]      off_wide;
  logic [CmpW-1:0]       idx_plus;
  logic                  last_word;
  logic                  miss;

  assign idx_wide  = WideW'(word_counter);
  assign off_wide  = idx_wide << width_shift(word_width);
  assign idx_plus  = CmpW'(word_counter) + CmpW'(1);
  assign last_word = (idx_plus == CmpW'(word_count));
  assign miss      = is_check && ((in_data & word_mask) != gen_pattern);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_counter <= '0;
    end else if (gen_ctrl.restart) begin
      word_counter <= '0;
    end else if (gen_ctrl.advance) begin
      word_counter <= last_word ? '0 : idx_plus[INDEX_BITS-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (is_step) begin
        m_axis_tdata <= {{PadW{1'b0}}, miss, off_wide[OFFSET_W-1:0],
                         idx_wide[WINDEX_W-1:0], gen_pattern};
        m_axis_tlast <= last_word;
      end else begin
        m_axis_tdata <= '0;
        m_axis_tlast <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/mtpc_gen.sv
// pattern generator: walking, own address, inversion and lfsr inversion modes
module mtpc_gen (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2:0]                  test_mode,
  input  logic [mtpc_pkg::DATA_W-1:0] word_mask,
  input  logic [mtpc_pkg::DATA_W-1:0] random_seed,
  input  mtpc_pkg::gen_ctrl_t         ctrl,
  output logic [mtpc_pkg::DATA_W-1:0] pattern
);
  import mtpc_pkg::*;

  logic [DATA_W-1:0] pattern_reg, pattern_reg_next;
  logic [DATA_W-1:0] lfsr_reg, lfsr_reg_next;
  logic [DATA_W-1:0] saved_word, saved_word_next;
  logic              odd_step, odd_step_next;

  logic [DATA_W-1:0] shifted;
  logic [DATA_W-1:0] lfsr_adv;

  always_comb begin
    shifted  = (pattern_reg << 1) & word_mask;
    lfsr_adv = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TOGGLE : '0);

    pattern_reg_next = pattern_reg;
    lfsr_reg_next    = lfsr_reg;
    saved_word_next  = saved_word;
    odd_step_next    = odd_step;

    case (test_mode)
      MODE_WALK_ZERO: begin
        pattern          = ~pattern_reg & word_mask;
        pattern_reg_next = (shifted == '0) ? DATA_W'(1) : shifted;
      end
      MODE_OWN_ADDR: begin
        pattern          = pattern_reg & word_mask;
        pattern_reg_next = (pattern_reg + DATA_W'(1)) & word_mask;
      end
      MODE_INVERSION: begin
        pattern          = pattern_reg & word_mask;
        pattern_reg_next = ~pattern_reg & word_mask;
      end
      MODE_RAND_INV: begin
        if (!odd_step) begin
          pattern         = lfsr_adv & word_mask;
          lfsr_reg_next   = lfsr_adv;
          saved_word_next = lfsr_adv & word_mask;
        end else begin
          pattern = ~saved_word & word_mask;
        end
        odd_step_next = ~odd_step;
      end
      default: begin
        // walking one, also for undefined modes
        pattern          = pattern_reg & word_mask;
        pattern_reg_next = (shifted == '0) ? DATA_W'(1) : shifted;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_reg <= DATA_W'(1);
      lfsr_reg    <= RESET_SEED;
      saved_word  <= '0;
      odd_step    <= 1'b0;
    end else if (ctrl.restart) begin
      pattern_reg <= (test_mode == MODE_OWN_ADDR || test_mode == MODE_INVERSION ||
                      test_mode == MODE_RAND_INV) ? '0 : DATA_W'(1);
      lfsr_reg    <= (random_seed == '0) ? DATA_W'(1) : random_seed;
      saved_word  <= '0;
      odd_step    <= 1'b0;
    end else if (ctrl.advance) begin
      pattern_reg <= pattern_reg_next;
      lfsr_reg    <= lfsr_reg_next;
      saved_word  <= saved_word_next;
      odd_step    <= odd_step_next;
    end
  end

endmodule

>>> verif/tb_memory_test_pattern_checker_core.sv
// self-checking testbench for the memory test pattern checker core
module tb_memory_test_pattern_checker_core;
  import mtpc_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1520;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 500000;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_ALIAS = 2'd3;   // spare code, behaves as 32 bits
  localparam logic [2:0] MODE_ALIAS = 3'd7;    // past the last mode, behaves as walking one
  localparam logic [31:0] GALOIS_TAPS = 32'hD000_0001;

  typedef struct packed {
    logic [31:0] pattern;
    logic [23:0] word_index;
    logic [25:0] byte_offset;
    logic        mismatch;
    logic        region_end;
  } pattern_result_t;

  typedef struct packed {
    logic [31:0] pat_reg;
    logic [31:0] lfsr;
    logic [31:0] saved;
    logic        odd;
    logic [23:0] counter;
  } gen_state_t;

  typedef struct packed {
    bit              is_cfg;
    logic [1:0]      reg_sel;
    logic [31:0]     value;      // register data or read data
    logic [1:0]      act;
    bit              known;
    pattern_result_t want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [1:0]             cfg_index = REG_TEST_MODE;
  logic [DATA_W-1:0]      cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;     // read_data
  logic [1:0]             s_axis_tuser = ACT_RESTART;  // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // pattern, word_index, byte_offset, mismatch, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // predictor copy of the configuration and generator
  logic [2:0]  cur_mode = MODE_WALK_ONE;
  logic [1:0]  cur_width = WIDTH_32;
  logic [31:0] cur_seed = 32'd1;
  logic [24:0] cur_count = 25'h100_0000;
  gen_state_t  gen;

  pattern_result_t pending_results[$];
  bit hold_due = 1'b0;
  int err_count = 0;
  int cycle_count = 0;
  int results_seen = 0, miss_seen = 0, ends_seen = 0;
  int n_fill = 0, n_check = 0, n_restart = 0, n_unknown = 0;
  int cfg_writes = 0, settings = 0;

  memory_test_pattern_checker_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] word_mask(input logic [1:0] code);
    return (code == WIDTH_8) ? 32'h0000_00FF : (code == WIDTH_16) ? 32'h0000_FFFF : '1;
  endfunction

  function automatic gen_state_t restarted_state();
    gen_state_t s;
    s = '0;
    s.pat_reg = (cur_mode == MODE_OWN_ADDR || cur_mode == MODE_INVERSION ||
                 cur_mode == MODE_RAND_INV) ? 32'd0 : 32'd1;
    s.lfsr = (cur_seed == 32'd0) ? 32'd1 : cur_seed;
    return s;
  endfunction

  function automatic void next_word(input gen_state_t cur, output gen_state_t nxt,
                                    output logic [31:0] word);
    logic [31:0] m, walk, l;
    m = word_mask(cur_width);
    nxt = cur;
    walk = (cur.pat_reg << 1) & m;
    if (walk == 32'd0) walk = 32'd1;
    case (cur_mode)
      MODE_WALK_ZERO: begin
        word = ~cur.pat_reg & m;
        nxt.pat_reg = walk;
      end
      MODE_OWN_ADDR: begin
        word = cur.pat_reg & m;
        nxt.pat_reg = (cur.pat_reg + 32'd1) & m;
      end
      MODE_INVERSION: begin
        word = cur.pat_reg & m;
        nxt.pat_reg = ~cur.pat_reg & m;
      end
      MODE_RAND_INV: begin
        // lfsr steps on even items, odd items return the complement
        if (!cur.odd) begin
          l = cur.lfsr >> 1;
          if (cur.lfsr[0]) l = l ^ GALOIS_TAPS;
          nxt.lfsr = l;
          word = l & m;
          nxt.saved = word;
        end else begin
          word = ~cur.saved & m;
        end
        nxt.odd = ~cur.odd;
      end
      default: begin
        word = cur.pat_reg & m;
        nxt.pat_reg = walk;
      end
    endcase
  endfunction

  function automatic pattern_result_t predict_pattern_item(input logic [1:0] act,
                                                           input logic [31:0] rd);
    pattern_result_t r;
    gen_state_t nxt;
    logic [31:0] word;
    r = '0;
    if (act == ACT_RESTART) begin
      gen = restarted_state();
    end else if (act == ACT_FILL || act == ACT_CHECK) begin
      next_word(gen, nxt, word);
      r.pattern = word;
      r.word_index = gen.counter;
      case (cur_width)
        WIDTH_8:  r.byte_offset = {2'b00, gen.counter};
        WIDTH_16: r.byte_offset = {1'b0, gen.counter, 1'b0};
        default:  r.byte_offset = {gen.counter, 2'b00};
      endcase
      r.mismatch = (act == ACT_CHECK) && ((rd & word_mask(cur_width)) != word);
      r.region_end = ({1'b0, gen.counter} + 25'd1) == cur_count;
      nxt.counter = r.region_end ? 24'd0 : gen.counter + 24'd1;
      gen = nxt;
    end
    return r;
  endfunction

  function automatic script_row_t cfg_row(input logic [1:0] sel, input logic [31:0] val);
    script_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.value = val;
    return row;
  endfunction

  function automatic script_row_t item_row(input logic [1:0] act, input logic [31:0] rd);
    script_row_t row;
    row = '0;
    row.act = act;
    row.value = rd;
    return row;
  endfunction

  function automatic script_row_t known_row(input logic [1:0] act, input logic [31:0] rd,
                                            input logic [31:0] pat, input logic [23:0] idx,
                                            input logic [25:0] off, input logic miss,
                                            input logic region_end);
    script_row_t row;
    row = item_row(act, rd);
    row.known = 1'b1;
    row.want = '{pat, idx, off, miss, region_end};
    return row;
  endfunction

  task automatic write_reg(input logic [1:0] sel, input logic [31:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      REG_TEST_MODE:   cur_mode = val[2:0];
      REG_WORD_WIDTH:  cur_width = val[1:0];
      REG_RANDOM_SEED: cur_seed = val;
      default:         cur_count = val[24:0];
    endcase
    cfg_writes++;
  endtask

  task automatic send_item(input logic [1:0] act, input logic [31:0] rd, input bit known,
                           input pattern_result_t want);
    pattern_result_t exp_r;
    exp_r = predict_pattern_item(act, rd);
    if (known) exp_r = want;
    cfg_wen <= 1'b0;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= rd;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    pending_results.push_back(exp_r);
    case (act)
      ACT_RESTART: n_restart++;
      ACT_FILL:    n_fill++;
      ACT_CHECK:   n_check++;
      default:     n_unknown++;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    pattern_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[82]) miss_seen++;
      if (m_axis_tlast) ends_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with nothing outstanding: tdata %h", m_axis_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("pattern", want.pattern, m_axis_tdata[31:0]);
        check_field("word_index", 32'(want.word_index), 32'(m_axis_tdata[55:32]));
        check_field("byte_offset", 32'(want.byte_offset), 32'(m_axis_tdata[81:56]));
        check_field("mismatch", 32'(want.mismatch), 32'(m_axis_tdata[82]));
        check_field("tdata fill", 32'd0, 32'(m_axis_tdata[87:83]));
        check_field("last", 32'(want.region_end), 32'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $error("no progress after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
      $display("tb_memory_test_pattern_checker_core: FAIL");
      $finish;
    end
  end

  // receiver: stall styles that change every span, plus long hold-offs
  initial begin : result_sink
    int span, style, k;
    while (rst) @(posedge clk);
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(HOLD_CYCLES / 4, HOLD_CYCLES)) @(posedge clk);
      end
      style = $urandom_range(0, 15);
      span = $urandom_range(16, 160);
      for (k = 0; k < span && !hold_due; k++) begin
        case (style)
          0, 1, 2, 3: m_axis_tready <= 1'b1;
          4, 5, 6:    m_axis_tready <= ($urandom_range(0, 3) != 0);
          7, 8:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          9, 10:      m_axis_tready <= (k % 3 != 0);
          11, 12:     m_axis_tready <= (k % 8 < 2);
          13, 14:     m_axis_tready <= 1'($urandom_range(0, 1));
          default:    hold_due = 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    script_row_t script[$];
    bit prev_cfg;
    int row_i, n, pick, gap, burst_left, phase_len, random_items;
    logic [1:0] act;
    logic [31:0] rd, m, peek_pat, val;
    gen_state_t peek_state;

    gen = restarted_state();
    script = '{
      // defaults after reset: walking one, 32-bit words
      known_row(ACT_RESTART, 32'hFFFF_FFFF, 32'd0, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_UNKNOWN, 32'h0000_0000, 32'd0, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_FILL, 32'h0000_0000, 32'd1, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_CHECK, 32'h0000_0002, 32'd2, 24'd1, 26'd4, 1'b0, 1'b0),
      known_row(ACT_CHECK, 32'hFFFF_FFFF, 32'd4, 24'd2, 26'd8, 1'b1, 1'b0),
      // unknown kind in mid-run leaves the generator alone
      known_row(ACT_UNKNOWN, 32'h1234_5678, 32'd0, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_FILL, 32'h0000_0000, 32'd8, 24'd3, 26'd12, 1'b0, 1'b0),
      // walking zero on bytes, three-word region wraps
      cfg_row(REG_WORD_COUNT, 32'd3),
      cfg_row(REG_TEST_MODE, 32'(MODE_WALK_ZERO)),
      cfg_row(REG_WORD_WIDTH, 32'(WIDTH_8)),
      known_row(ACT_RESTART, 32'h0000_0000, 32'd0, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_FILL, 32'h0000_0000, 32'hFE, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_CHECK, 32'hFFFF_FFFD, 32'hFD, 24'd1, 26'd1, 1'b0, 1'b0),
      known_row(ACT_FILL, 32'h0000_0000, 32'hFB, 24'd2, 26'd2, 1'b0, 1'b1),
      known_row(ACT_CHECK, 32'h0000_00F7, 32'hF7, 24'd0, 26'd0, 1'b0, 1'b0),
      // own address on 16-bit words, empty region never ends
      cfg_row(REG_TEST_MODE, 32'(MODE_OWN_ADDR)),
      cfg_row(REG_WORD_WIDTH, 32'(WIDTH_16)),
      cfg_row(REG_WORD_COUNT, 32'd0),
      known_row(ACT_RESTART, 32'h0000_0000, 32'd0, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_FILL, 32'h0000_0000, 32'd0, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_CHECK, 32'h0001_0001, 32'd1, 24'd1, 26'd2, 1'b0, 1'b0),
      known_row(ACT_CHECK, 32'h0000_0000, 32'd2, 24'd2, 26'd4, 1'b1, 1'b0),
      // inversion with the spare width code and an oversized region
      cfg_row(REG_TEST_MODE, 32'(MODE_INVERSION)),
      cfg_row(REG_WORD_WIDTH, 32'(WIDTH_ALIAS)),
      cfg_row(REG_WORD_COUNT, 32'hFFFF_FFFF),
      item_row(ACT_RESTART, 32'h0000_0000),
      item_row(ACT_FILL, 32'h0000_0000),
      item_row(ACT_CHECK, 32'h0000_0000),
      // random inversion from a zero seed
      cfg_row(REG_TEST_MODE, 32'(MODE_RAND_INV)),
      cfg_row(REG_RANDOM_SEED, 32'd0),
      cfg_row(REG_WORD_WIDTH, 32'(WIDTH_32)),
      item_row(ACT_RESTART, 32'h0000_0000),
      item_row(ACT_FILL, 32'h0000_0000),
      item_row(ACT_CHECK, 32'h5555_AAAA),
      // mode past the end acts as walking one, one-word region
      cfg_row(REG_TEST_MODE, 32'(MODE_ALIAS)),
      cfg_row(REG_WORD_COUNT, 32'd1),
      known_row(ACT_RESTART, 32'h0000_0000, 32'd0, 24'd0, 26'd0, 1'b0, 1'b0),
      known_row(ACT_FILL, 32'h0000_0000, 32'd1, 24'd0, 26'd0, 1'b0, 1'b1),
      known_row(ACT_FILL, 32'h0000_0000, 32'd2, 24'd0, 26'd0, 1'b0, 1'b1),
      // random inversion on bytes from an all-ones seed
      cfg_row(REG_RANDOM_SEED, 32'hFFFF_FFFF),
      cfg_row(REG_TEST_MODE, 32'(MODE_RAND_INV)),
      cfg_row(REG_WORD_WIDTH, 32'(WIDTH_8)),
      cfg_row(REG_WORD_COUNT, 32'h0100_0000),
      item_row(ACT_RESTART, 32'h0000_0000),
      item_row(ACT_CHECK, 32'hA5A5_A5A5)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_cfg = 1'b0;
    for (row_i = 0; row_i < script.size(); row_i++) begin
      if (script[row_i].is_cfg) begin
        if (!prev_cfg) begin
          wait_idle();
          settings++;
        end
        write_reg(script[row_i].reg_sel, script[row_i].value);
      end else begin
        send_item(script[row_i].act, script[row_i].value, script[row_i].known,
                  script[row_i].want);
      end
      prev_cfg = script[row_i].is_cfg;
    end

    // random phases, each on a fresh setting written while idle
    hold_due = 1'b1;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      settings++;
      if ($urandom_range(0, 9) < 7) begin
        val = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        write_reg(REG_TEST_MODE, val);
      end
      if ($urandom_range(0, 9) < 6) write_reg(REG_WORD_WIDTH, $urandom_range(0, 3));
      if ($urandom_range(0, 9) < 4) begin
        case ($urandom_range(0, 5))
          0:       val = 32'd0;
          1:       val = 32'd1;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h8000_0000;
          default: val = $urandom;
        endcase
        write_reg(REG_RANDOM_SEED, val);
      end
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 9))
          0:       val = 32'd0;
          1:       val = 32'd1;
          2:       val = 32'd2;
          3:       val = 32'h0100_0000;
          4:       val = 32'hFFFF_FFFF;
          5:       val = $urandom;
          default: val = $urandom_range(3, 48);
        endcase
        write_reg(REG_WORD_COUNT, val);
      end
      if ($urandom_range(0, 3) != 0) send_item(ACT_RESTART, $urandom, 1'b0, '0);

      phase_len = (settings == 1) ? 300 : $urandom_range(30, 120);
      if (random_items == 0) phase_len = 300;
      burst_left = 0;
      for (n = 0; n < phase_len; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) == 0) gap = 0;
          else gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
          if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            cfg_wen <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        act = (pick < 3) ? ACT_RESTART : (pick < 6) ? ACT_UNKNOWN :
              (pick < 50) ? ACT_FILL : ACT_CHECK;
        // checks read back the right word, the right word with stray bits above the word width, or a corrupted word
        m = word_mask(cur_width);
        next_word(gen, peek_state, peek_pat);
        case ($urandom_range(0, 6))
          0, 1, 2: rd = peek_pat;
          3:       rd = peek_pat | ($urandom & ~m);
          4:       rd = peek_pat ^ (32'd1 << $urandom_range(0, 31));
          default: rd = $urandom;
        endcase
        send_item(act, rd, 1'b0, '0);
        if (act != ACT_UNKNOWN) random_items++;
      end
    end

    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d fill, %0d check, %0d restart, %0d unknown items over %0d settings",
             n_fill, n_check, n_restart, n_unknown, settings);
    $display("%0d results checked, %0d mismatches flagged, %0d region ends, %0d reg writes",
             results_seen, miss_seen, ends_seen, cfg_writes);
    if (err_count == 0) begin
      $display("tb_memory_test_pattern_checker_core: PASS");
    end else begin
      $display("tb_memory_test_pattern_checker_core: FAIL");
    end
    $finish;
  end

endmodule
